@@ rtl/core/masked_template_byte_matcher_top_macros.svh @@
// Assertion macros for the masked template byte matcher.
// Used by the top level and the result buffer; no other dependencies.
`ifndef MASKED_TEMPLATE_BYTE_MATCHER_TOP_MACROS_SVH
`define MASKED_TEMPLATE_BYTE_MATCHER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MTBM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MTBM_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTBM_ASSERT(label, clk, rst, prop, msg)
`define MTBM_ASSERT_ANY(label, clk, prop, msg)
`endif
`endif

@@ rtl/core/mtbm_pkg.sv @@
// Shared types and constants of the masked template byte matcher.
// No dependencies.
`default_nettype none

package mtbm_pkg;

  localparam int DEFAULT_TEMPLATE_DEPTH = 32;

  localparam logic       KIND_STREAM = 1'b0;
  localparam logic       KIND_LOAD   = 1'b1;

  localparam logic [1:0] CLS_LITERAL  = 2'd0;
  localparam logic [1:0] CLS_FIXED    = 2'd1;
  localparam logic [1:0] CLS_VARIABLE = 2'd2;

  localparam logic [5:0] LENGTH_RESET = 6'd16;
  localparam logic [5:0] FIELD_MAX    = 6'd63;

  typedef struct packed {
    logic [7:0] chr;
    logic [1:0] cls;
  } mtbm_entry_t;

  typedef struct packed {
    logic       captured_valid;
    logic [4:0] field_index;
    logic [7:0] captured_byte;
    logic       frame_done;
    logic       mismatch;
  } mtbm_result_t;

endpackage

`default_nettype wire

@@ rtl/core/mtbm_template_mem.sv @@
// Template store: one write port, two registered read ports.
// A write to an address being read in the same cycle forwards the new entry.
// Depends on mtbm_pkg.
`default_nettype none

module mtbm_template_mem
  import mtbm_pkg::*;
#(
  parameter int TEMPLATE_DEPTH = DEFAULT_TEMPLATE_DEPTH,
  localparam int AW = $clog2(TEMPLATE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire mtbm_entry_t   wentry,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output mtbm_entry_t        rentry_a,
  output logic [7:0]         rchar_b
);

  mtbm_entry_t mem [TEMPLATE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wentry;
    end
  end

  always_ff @(posedge clk) begin
    rentry_a <= (we && waddr == raddr_a) ? wentry : mem[raddr_a];
    rchar_b  <= (we && waddr == raddr_b) ? wentry.chr : mem[raddr_b].chr;
  end

endmodule

`default_nettype wire

@@ rtl/core/mtbm_out_buf.sv @@
// Two-entry result buffer between the matcher and the result channel.
// Depends on mtbm_pkg and the assertion macro header.
`default_nettype none

`include "masked_template_byte_matcher_top_macros.svh"

module mtbm_out_buf
  import mtbm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire mtbm_result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  wire logic         out_ready,
  output mtbm_result_t      out_data
);

  mtbm_result_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `MTBM_ASSERT(a_no_push_full, clk, rst, !(push && full && !pop), "result pushed into full buffer")
  `MTBM_ASSERT_ANY(a_reset_empty, clk, (rst |=> count == 2'd0), "buffer not empty after reset")

endmodule

`default_nettype wire

@@ rtl/core/masked_template_byte_matcher_top.sv @@
// Masked template byte matcher: walks a byte stream through a stored template.
// Uses mtbm_pkg, mtbm_template_mem, mtbm_out_buf and the assertion macro header.
//
// Usage:
//  - Request channel (in_valid/in_ready): kind 1 loads one template entry
//    (entry_index, entry_char, entry_class); kind 0 presents a stream byte.
//  - Every request yields exactly one result on the result channel
//    (out_valid/out_ready): captured byte with its field index, frame_done,
//    mismatch. A load yields an all-zero result.
//  - Configuration (cfg_valid/cfg_ready, cfg_data) sets template_length;
//    write it only while no request is in flight.
//  - Throughput is one request per cycle while in_ready is high. The
//    template entry at the match position and the next entry's character
//    are prefetched from the template memory, addressed by the position
//    computed this cycle, so the compare-and-advance loop needs no wait state.
//  - Each result is registered in the result buffer before it appears on out_valid.
//  - A two-entry result buffer lets a request be taken while one result
//    waits; in_ready drops only when both entries are held, or while
//    rst is high.
//  - Reset (rst, synchronous): match position 0, field count 0, length 16,
//    result buffer empty. Template entries are undefined until loaded.
`default_nettype none

`include "masked_template_byte_matcher_top_macros.svh"

module masked_template_byte_matcher_top
  import mtbm_pkg::*;
#(
  parameter int TEMPLATE_DEPTH = DEFAULT_TEMPLATE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  input  wire logic [4:0] entry_index,
  input  wire logic [7:0] entry_char,
  input  wire logic [1:0] entry_class,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            captured_valid,
  output logic [4:0]      field_index,
  output logic [7:0]      captured_byte,
  output logic            frame_done,
  output logic            mismatch,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [5:0] cfg_data
);

  localparam int AW = $clog2(TEMPLATE_DEPTH);
  localparam int PW = (AW + 1 > 7) ? AW + 1 : 7;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TEMPLATE_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P   = PW'(TEMPLATE_DEPTH);

  logic [5:0]    template_length;
  logic [AW-1:0] pos;
  logic          prev_lit;
  logic [5:0]    cur_field;

  logic [AW-1:0] pos_next;
  logic          prev_lit_next;
  logic [5:0]    cur_field_next;

  mtbm_entry_t   cur_entry;
  logic [7:0]    term_char;
  mtbm_entry_t   wentry;
  logic          we;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;

  logic          in_fire;
  logic          byte_fire;
  logic          load_fire;
  logic          buf_full;
  logic          take;
  logic          skip;
  logic          hit;
  logic          miss;
  logic          done;
  logic [5:0]    field_new;
  logic [PW-1:0] step_pos;
  logic [PW-1:0] len_eff;
  mtbm_result_t  result;
  mtbm_result_t  out_data;

  assign in_ready  = !buf_full && !rst;
  assign cfg_ready = !rst;
  assign in_fire   = in_valid && in_ready;
  assign byte_fire = in_fire && (kind == KIND_STREAM);
  assign load_fire = in_fire && (kind == KIND_LOAD);

  // Match decision for the byte against the prefetched entry.
  always_comb begin
    take = (cur_entry.cls == CLS_FIXED) ||
           (cur_entry.cls == CLS_VARIABLE && term_char != data_byte);
    skip = (cur_entry.cls == CLS_VARIABLE) && (term_char == data_byte);
    hit  = !take && !skip && (cur_entry.chr == data_byte);
    miss = !take && !skip && !hit;

    field_new = cur_field + 6'((prev_lit && cur_field != FIELD_MAX) ? 1 : 0);

    step_pos = PW'(pos);
    if (skip) begin
      step_pos = PW'(pos) + PW'(2);
    end else if (hit || cur_entry.cls == CLS_FIXED) begin
      step_pos = PW'(pos) + PW'(1);
    end

    len_eff = (PW'(template_length) > DEPTH_P) ? DEPTH_P : PW'(template_length);
    done    = !miss && (step_pos >= len_eff);
  end

  always_comb begin
    pos_next       = pos;
    prev_lit_next  = prev_lit;
    cur_field_next = cur_field;
    result         = '0;
    if (byte_fire) begin
      result.mismatch   = miss;
      result.frame_done = done;
      if (take) begin
        result.captured_valid = 1'b1;
        result.field_index    = 5'(field_new - 6'd1);
        result.captured_byte  = data_byte;
      end
      if (miss || done) begin
        pos_next       = '0;
        prev_lit_next  = 1'b1;
        cur_field_next = '0;
      end else begin
        pos_next       = step_pos[AW-1:0];
        prev_lit_next  = !take;
        cur_field_next = take ? field_new : cur_field;
      end
    end
  end

  // Prefetch the entries for the next byte from the position decided now.
  assign raddr_a = rst ? '0 : pos_next;
  assign raddr_b = (raddr_a == LAST_ADDR) ? '0 : raddr_a + AW'(1);

  assign we         = load_fire && (int'(entry_index) < TEMPLATE_DEPTH);
  assign wentry.chr = entry_char;
  assign wentry.cls = entry_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      template_length <= LENGTH_RESET;
      pos             <= '0;
      prev_lit        <= 1'b1;
      cur_field       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        template_length <= cfg_data;
      end
      pos       <= pos_next;
      prev_lit  <= prev_lit_next;
      cur_field <= cur_field_next;
    end
  end

  mtbm_template_mem #(
    .TEMPLATE_DEPTH(TEMPLATE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (AW'(entry_index)),
    .wentry  (wentry),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rentry_a(cur_entry),
    .rchar_b (term_char)
  );

  mtbm_out_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (in_fire),
    .push_data(result),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign captured_valid = out_data.captured_valid;
  assign field_index    = out_data.field_index;
  assign captured_byte  = out_data.captured_byte;
  assign frame_done     = out_data.frame_done;
  assign mismatch       = out_data.mismatch;

  `MTBM_ASSERT(a_pos_in_range, clk, rst, (int'(pos) < TEMPLATE_DEPTH), "match position out of range")
  `MTBM_ASSERT(a_restart, clk, rst, ((byte_fire && (miss || done)) |=> (pos == '0 && prev_lit && cur_field == '0)), "no restart after mismatch or frame end")
  `MTBM_ASSERT(a_load_holds_pos, clk, rst, (load_fire |=> $stable(pos) && $stable(cur_field)), "template load moved match state")

endmodule

`default_nettype wire
